// ----- src/pifd_pkg.sv -----
`timescale 1ns / 1ps

package pifd_pkg;

    localparam int FREQ_W  = 33;
    localparam int PFD_W   = 25;
    localparam int INT_W   = 16;
    localparam int FRAC_W  = 12;
    localparam int REG0_W  = 32;
    localparam int PROD_W  = PFD_W + FRAC_W;

    // Fractional modulus; FRAC_W must cover it
    localparam int MODULUS = 4095;

    // One quotient bit per cell
    localparam int INT_CELLS  = INT_W;
    localparam int FRAC_CELLS = FRAC_W;
    localparam int BITS_W     = INT_W;

    localparam int S_TDATA_W = ((FREQ_W + 7) / 8) * 8;
    localparam int M_PAY_W   = 2 + INT_W + FRAC_W + REG0_W;
    localparam int M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;

    localparam logic [FREQ_W-1:0] FREQ_MIN_HZ = 33'd34600000;
    localparam logic [FREQ_W-1:0] FREQ_MAX_HZ = 33'd4400000000;
    localparam logic [INT_W:0]    INT_MIN_VAL = 17'd23;
    localparam logic [PFD_W-1:0]  PFD_RESET   = 25'd10000000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAND = 2'd1,
        ST_INT  = 2'd2
    } pifd_status_t;

    // Item as it travels down the chain. rem is the partial remainder,
    // bits holds the dividend bits still to be consumed at the top and the
    // quotient bits collected so far at the bottom.
    typedef struct packed {
        pifd_status_t        status;
        logic [INT_W-1:0]    int_q;
        logic [PFD_W-1:0]    rem;
        logic [BITS_W-1:0]   bits;
    } pifd_item_t;

endpackage

// ----- src/pifd_div_cell.sv -----
`timescale 1ns / 1ps

// One restoring division step: shift in the next dividend bit, subtract
// the divisor when it fits, shift out one quotient bit.
module pifd_div_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pifd_pkg::PFD_W-1:0]   pfd,
    input  logic                         in_valid,
    input  pifd_pkg::pifd_item_t         in_item,
    output logic                         in_ready,
    output logic                         out_valid,
    output pifd_pkg::pifd_item_t         out_item,
    input  logic                         out_ready
);

    logic                       valid_reg;
    pifd_pkg::pifd_item_t       item_reg;
    pifd_pkg::pifd_item_t       item_next;
    logic [pifd_pkg::PFD_W:0]   trial;
    logic [pifd_pkg::PFD_W:0]   diff;
    logic                       take;

    always_comb begin
        trial = {in_item.rem, in_item.bits[pifd_pkg::BITS_W-1]};
        diff  = trial - {1'b0, pfd};
        take  = (trial >= {1'b0, pfd});
        item_next      = in_item;
        item_next.rem  = take ? diff[pifd_pkg::PFD_W-1:0] : trial[pifd_pkg::PFD_W-1:0];
        item_next.bits = {in_item.bits[pifd_pkg::BITS_W-2:0], take};
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- src/pifd_in_stage.sv -----
`timescale 1ns / 1ps

// Band check, divisor check and setup of the integer division.
module pifd_in_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pifd_pkg::PFD_W-1:0]   pfd,
    input  logic                         in_valid,
    input  logic [pifd_pkg::FREQ_W-1:0]  freq_hz,
    output logic                         in_ready,
    output logic                         out_valid,
    output pifd_pkg::pifd_item_t         out_item,
    input  logic                         out_ready
);

    localparam int WIDE_W = pifd_pkg::PFD_W + pifd_pkg::INT_W;

    logic                   valid_reg;
    pifd_pkg::pifd_item_t   item_reg;
    pifd_pkg::pifd_item_t   item_next;
    logic                   out_of_band;
    logic                   int_overflow;

    always_comb begin
        out_of_band  = (freq_hz < pifd_pkg::FREQ_MIN_HZ) || (freq_hz > pifd_pkg::FREQ_MAX_HZ);
        // quotient would need more than INT_W bits
        int_overflow = (WIDE_W'(freq_hz) >= {pfd, {pifd_pkg::INT_W{1'b0}}});
        item_next.int_q = '0;
        item_next.rem   = pifd_pkg::PFD_W'(freq_hz[pifd_pkg::FREQ_W-1:pifd_pkg::INT_W]);
        item_next.bits  = freq_hz[pifd_pkg::INT_W-1:0];
        if (out_of_band) begin
            item_next.status = pifd_pkg::ST_BAND;
        end else if ((pfd == '0) || int_overflow) begin
            item_next.status = pifd_pkg::ST_INT;
        end else begin
            item_next.status = pifd_pkg::ST_OK;
        end
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- src/pifd_mul_stage.sv -----
`timescale 1ns / 1ps

// Latch INT and form the rounded fraction numerator rem*MODULUS + pfd/2.
module pifd_mul_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pifd_pkg::PFD_W-1:0]   pfd,
    input  logic                         in_valid,
    input  pifd_pkg::pifd_item_t         in_item,
    output logic                         in_ready,
    output logic                         out_valid,
    output pifd_pkg::pifd_item_t         out_item,
    input  logic                         out_ready
);

    localparam int PAD_W = pifd_pkg::BITS_W - pifd_pkg::FRAC_W;

    logic                           valid_reg;
    pifd_pkg::pifd_item_t           item_reg;
    pifd_pkg::pifd_item_t           item_next;
    logic [pifd_pkg::PROD_W-1:0]    num;

    always_comb begin
        num = pifd_pkg::PROD_W'(in_item.rem) * pifd_pkg::PROD_W'(pifd_pkg::MODULUS)
            + pifd_pkg::PROD_W'(pfd[pifd_pkg::PFD_W-1:1]);
        item_next.status = in_item.status;
        item_next.int_q  = in_item.bits;
        item_next.rem    = num[pifd_pkg::PROD_W-1:pifd_pkg::FRAC_W];
        item_next.bits   = {num[pifd_pkg::FRAC_W-1:0], {PAD_W{1'b0}}};
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- src/pifd_out_stage.sv -----
`timescale 1ns / 1ps

// Fraction wrap, INT range check and packing into the output register.
module pifd_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    input  pifd_pkg::pifd_item_t             in_item,
    output logic                             in_ready,
    output logic                             m_valid,
    output logic [pifd_pkg::M_TDATA_W-1:0]   m_data,
    input  logic                             m_ready
);

    localparam int PAD_W = pifd_pkg::M_TDATA_W - pifd_pkg::M_PAY_W;

    logic                               valid_reg;
    logic [pifd_pkg::M_TDATA_W-1:0]     data_reg;
    logic [pifd_pkg::M_TDATA_W-1:0]     data_next;
    logic [pifd_pkg::FRAC_W-1:0]        fr;
    logic [pifd_pkg::FRAC_W-1:0]        fr_fin;
    logic                               wrap;
    logic [pifd_pkg::INT_W:0]           int_inc;
    pifd_pkg::pifd_status_t             status;
    logic [pifd_pkg::INT_W-1:0]         int_out;
    logic [pifd_pkg::FRAC_W-1:0]        frac_out;
    logic [pifd_pkg::REG0_W-1:0]        reg0_out;

    always_comb begin
        fr      = in_item.bits[pifd_pkg::FRAC_W-1:0];
        wrap    = (32'(fr) >= 32'(pifd_pkg::MODULUS));
        fr_fin  = wrap ? '0 : fr;
        int_inc = {1'b0, in_item.int_q} + (pifd_pkg::INT_W + 1)'(wrap);
        status  = in_item.status;
        if ((status == pifd_pkg::ST_OK)
            && ((int_inc < pifd_pkg::INT_MIN_VAL) || int_inc[pifd_pkg::INT_W])) begin
            status = pifd_pkg::ST_INT;
        end
        if (status == pifd_pkg::ST_OK) begin
            int_out  = int_inc[pifd_pkg::INT_W-1:0];
            frac_out = fr_fin;
        end else begin
            int_out  = '0;
            frac_out = '0;
        end
        reg0_out  = {1'b0, int_out, frac_out, 3'b000};
        data_next = {{PAD_W{1'b0}}, reg0_out, frac_out, int_out, status};
    end

    assign in_ready = ~valid_reg | m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- src/pll_int_frac_divider_calc.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload (low bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready   freq_hz[32:0], zero pad to 40
// m_axis    out  m_axis_tvalid/m_axis_tready   status[1:0], int_value[17:2],
//                                              frac_value[29:18], reg0_word[61:30]
// cfg       in   cfg_wr_en                     pfd_hz[24:0]
//
// One item per cycle sustained while m_axis accepts; the chain is one check stage, 16
// integer division cells, one multiply stage, 12 fraction division cells and
// the output register. Each cell resolves one quotient bit.
// Reset (aresetn low, synchronous) empties the chain and loads pfd_hz with
// 10 MHz. Ready is combinational through the chain, so a stall on m_axis
// reaches back through full cells in the same cycle; bubbles are squeezed
// out, so s_axis_tready stays high until every cell holds an item.
module pll_int_frac_divider_calc (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pifd_pkg::PFD_W-1:0]       cfg_wr_data,     // pfd_hz
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pifd_pkg::S_TDATA_W-1:0]   s_axis_tdata,    // freq_hz[32:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[1:0], int_value[17:2], frac_value[29:18], reg0_word[61:30]
    output logic [pifd_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NI = pifd_pkg::INT_CELLS;
    localparam int NF = pifd_pkg::FRAC_CELLS;

    logic [pifd_pkg::PFD_W-1:0] pfd_reg;

    // Hold the divisor; the user must change it only while the chain is empty, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pfd_reg <= pifd_pkg::PFD_RESET;
        end else if (cfg_wr_en) begin
            pfd_reg <= cfg_wr_data;
        end
    end

    // Integer chain taps: index 0 is the check stage output
    logic                   iv [0:NI];
    logic                   ir [0:NI];
    pifd_pkg::pifd_item_t   ii [0:NI];

    // Fraction chain taps: index 0 is the multiply stage output
    logic                   fv [0:NF];
    logic                   fr [0:NF];
    pifd_pkg::pifd_item_t   fi [0:NF];

    pifd_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pfd       (pfd_reg),
        .in_valid  (s_axis_tvalid),
        .freq_hz   (s_axis_tdata[pifd_pkg::FREQ_W-1:0]),
        .in_ready  (s_axis_tready),
        .out_valid (iv[0]),
        .out_item  (ii[0]),
        .out_ready (ir[0])
    );

    // Advance the integer quotient one bit per cell
    for (genvar k = 0; k < NI; k++) begin : g_int
        pifd_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .pfd       (pfd_reg),
            .in_valid  (iv[k]),
            .in_item   (ii[k]),
            .in_ready  (ir[k]),
            .out_valid (iv[k+1]),
            .out_item  (ii[k+1]),
            .out_ready (ir[k+1])
        );
    end

    pifd_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pfd       (pfd_reg),
        .in_valid  (iv[NI]),
        .in_item   (ii[NI]),
        .in_ready  (ir[NI]),
        .out_valid (fv[0]),
        .out_item  (fi[0]),
        .out_ready (fr[0])
    );

    // Advance the rounded fraction one bit per cell
    for (genvar k = 0; k < NF; k++) begin : g_frac
        pifd_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .pfd       (pfd_reg),
            .in_valid  (fv[k]),
            .in_item   (fi[k]),
            .in_ready  (fr[k]),
            .out_valid (fv[k+1]),
            .out_item  (fi[k+1]),
            .out_ready (fr[k+1])
        );
    end

    pifd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fv[NF]),
        .in_item  (fi[NF]),
        .in_ready (fr[NF]),
        .m_valid  (m_axis_tvalid),
        .m_data   (m_axis_tdata),
        .m_ready  (m_axis_tready)
    );

    // Field views of the result for the checks below
    logic [1:0]                     chk_status;
    logic [pifd_pkg::INT_W-1:0]     chk_int;
    logic [pifd_pkg::FRAC_W-1:0]    chk_frac;
    logic [pifd_pkg::REG0_W-1:0]    chk_reg0;

    assign chk_status = m_axis_tdata[1:0];
    assign chk_int    = m_axis_tdata[2 +: pifd_pkg::INT_W];
    assign chk_frac   = m_axis_tdata[2 + pifd_pkg::INT_W +: pifd_pkg::FRAC_W];
    assign chk_reg0   = m_axis_tdata[2 + pifd_pkg::INT_W + pifd_pkg::FRAC_W +: pifd_pkg::REG0_W];

    // Input side only blocks when the output is stalled and the chain is full
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input blocked without output stall");

    a_ok_int_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (chk_status == pifd_pkg::ST_OK)) |->
            ((17'(chk_int) >= pifd_pkg::INT_MIN_VAL)
             && (32'(chk_frac) < 32'(pifd_pkg::MODULUS))))
        else $error("ok result with INT or FRAC out of range");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (chk_status != pifd_pkg::ST_OK)) |->
            ((chk_int == '0) && (chk_frac == '0) && (chk_reg0 == '0)))
        else $error("error result with nonzero fields");

    a_reg0_packing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (chk_reg0 == {1'b0, chk_int, chk_frac, 3'b000}))
        else $error("reg0 word does not match INT and FRAC");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((chk_status == pifd_pkg::ST_OK)
                           || (chk_status == pifd_pkg::ST_BAND)
                           || (chk_status == pifd_pkg::ST_INT)))
        else $error("undefined status code");

endmodule
